FILE: sv/bst_pkg.sv
`timescale 1ns / 1ps
// bst_pkg: shared types and fixed constants of the BMP-to-tricolor-planes decoder.
// No dependencies; used by the decoder top, bst_classify and bst_palette_ram.
package bst_pkg;

    // item operations
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_BMP     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    // pixel depth modes
    localparam logic [1:0] MODE_24 = 2'd0;
    localparam logic [1:0] MODE_8  = 2'd1;
    localparam logic [1:0] MODE_4  = 2'd2;

    // pixel classes
    localparam logic [1:0] CLS_WHITE = 2'd0;
    localparam logic [1:0] CLS_BLACK = 2'd1;
    localparam logic [1:0] CLS_RED   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_RED_MIN = 2'd0;
    localparam logic [1:0] REG_GB_MAX  = 2'd1;
    localparam logic [1:0] REG_DARK    = 2'd2;

    localparam logic [7:0] RED_MIN_RST = 8'd180;
    localparam logic [7:0] GB_MAX_RST  = 8'd80;
    localparam logic [7:0] DARK_RST    = 8'd128;

    localparam int unsigned HEADER_BYTES = 54;
    localparam logic [15:0] BMP_MAGIC    = 16'h4D42;   // "BM", little endian

    // luminance weights (x1000)
    localparam logic [17:0] LUM_R    = 18'd299;
    localparam logic [17:0] LUM_G    = 18'd587;
    localparam logic [17:0] LUM_B    = 18'd114;
    localparam logic [17:0] LUM_UNIT = 18'd1000;

    typedef struct packed {
        logic [7:0] red_min;
        logic [7:0] gb_max;
        logic [7:0] dark;
    } t_cfg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

endpackage

FILE: sv/bst_stream_if.sv
`timescale 1ns / 1ps
// bst_in_if / bst_out_if: valid-ready channels of the decoder.
// Depends on nothing.
interface bst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [12:0] read_address;
    modport source (output valid, output operation, output data_byte,
                    output read_address, input ready);
    modport sink   (input valid, input operation, input data_byte,
                    input read_address, output ready);
endinterface

interface bst_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [30:0] rows_done;
    logic [7:0]  black_byte;
    logic [7:0]  red_byte;
    modport source (output valid, output status, output rows_done,
                    output black_byte, output red_byte, input ready);
    modport sink   (input valid, input status, input rows_done,
                    input black_byte, input red_byte, output ready);
endinterface

FILE: sv/bmp_stream_to_tricolor_planes.sv
`timescale 1ns / 1ps
// bmp_stream_to_tricolor_planes: streaming BMP decoder into black and red bit planes.
// Depends on bst_pkg, bst_stream_if, bst_classify, bst_row_ram, bst_palette_ram,
// bst_plane_ram.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+------------------------------------------
//  i_in     | in  | valid/ready     | operation, data_byte, read_address
//  o_out    | out | valid/ready     | status, rows_done, black_byte, red_byte
//  APB      | in  | psel/penable    | paddr, pwdata (regs at 0x0, 0x4, 0x8)
//
// One item at a time: start, plain and skipped bytes pass execute and done to the output
//   register; a plane read adds a RAM read; a palette entry or 24-bit pixel runs the
//   2-stage classifier, its class then going to the palette RAM or, for a non-white
//   panel pixel, into a plane RAM read-modify-write. The last byte of an indexed row
//   walks the row: row RAM, palette RAM, plane RAM read then write per visible pixel,
//   white pixels skipping the plane RAM. Reset and header completion sweep the plane
//   RAM (4736 byte pairs by default), one pair a cycle; no item is taken then. A
//   finished result waits in the output register; the next item is taken meanwhile.
module bmp_stream_to_tricolor_planes #(
    parameter int PANEL_WIDTH      = 296,
    parameter int PANEL_HEIGHT     = 128,
    parameter int PALETTE_ENTRIES  = 256,
    parameter int ROW_BUFFER_BYTES = 296
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bst_in_if.sink      i_in,
    bst_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int PRB  = (PANEL_WIDTH + 7) / 8;          // plane bytes per row
    localparam int PB   = PRB * PANEL_HEIGHT;             // plane bytes
    localparam int PAW  = (PB > 1) ? $clog2(PB) : 1;
    localparam int RAW  = $clog2(ROW_BUFFER_BYTES);
    localparam int PIW  = $clog2(PALETTE_ENTRIES);
    localparam int YW   = $clog2(PANEL_HEIGHT + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_HDR_FIN  = 4'd3;
    localparam logic [3:0] S_CLEAR    = 4'd4;
    localparam logic [3:0] S_CLS1     = 4'd5;
    localparam logic [3:0] S_CLS2     = 4'd6;
    localparam logic [3:0] S_CLS3     = 4'd7;
    localparam logic [3:0] S_DEC_BASE = 4'd8;
    localparam logic [3:0] S_DEC_X    = 4'd9;
    localparam logic [3:0] S_DEC_ROW  = 4'd10;
    localparam logic [3:0] S_DEC_PAL  = 4'd11;
    localparam logic [3:0] S_PAINT_WR = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    // ---------------- configuration registers ----------------
    logic [7:0] r_red_min, r_gb_max, r_dark;
    bst_pkg::t_cfg cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_min <= bst_pkg::RED_MIN_RST;
            r_gb_max  <= bst_pkg::GB_MAX_RST;
            r_dark    <= bst_pkg::DARK_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                bst_pkg::REG_RED_MIN: r_red_min <= pwdata[7:0];
                bst_pkg::REG_GB_MAX:  r_gb_max  <= pwdata[7:0];
                bst_pkg::REG_DARK:    r_dark    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bst_pkg::REG_RED_MIN: prdata = {24'd0, r_red_min};
            bst_pkg::REG_GB_MAX:  prdata = {24'd0, r_gb_max};
            bst_pkg::REG_DARK:    prdata = {24'd0, r_dark};
            default:              prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = '{red_min: r_red_min, gb_max: r_gb_max, dark: r_dark};

    // ---------------- decoder state ----------------
    logic [3:0]     r_state, n_state;
    logic [1:0]     r_op, n_op;
    logic [7:0]     r_din, n_din;
    logic [12:0]    r_raddr, n_raddr;
    logic [5:0]     r_hcount, n_hcount;
    logic [15:0]    r_sig, n_sig;           // header shift-ins, little endian
    logic [31:0]    r_off_sh, n_off_sh;
    logic [31:0]    r_w_sh, n_w_sh;
    logic [31:0]    r_h_sh, n_h_sh;
    logic [15:0]    r_bpp_sh, n_bpp_sh;
    logic [31:0]    r_compr_sh, n_compr_sh;
    logic [31:0]    r_pix_off, n_pix_off;
    logic [31:0]    r_fpos, n_fpos;
    logic [31:0]    r_width, n_width;
    logic [31:0]    r_height, n_height;
    logic           r_top, n_top;
    logic [1:0]     r_mode, n_mode;
    logic [31:0]    r_pal_recv, n_pal_recv;
    logic [31:0]    r_pal_len, n_pal_len;
    logic [31:0]    r_stride, n_stride;
    logic [31:0]    r_pix_bytes, n_pix_bytes;
    logic [31:0]    r_row_index, n_row_index;
    logic [31:0]    r_rbc, n_rbc;
    logic [1:0]     r_phase, n_phase;       // row byte count mod 3 (24-bit)
    logic [31:0]    r_pixcnt, n_pixcnt;     // pixels completed in row (24-bit)
    logic           r_ok, n_ok;
    logic [1:0]     r_err, n_err;
    logic [7:0]     r_b0, n_b0, r_b1, n_b1, r_b2, n_b2;
    logic [PIW-1:0] r_pal_idx, n_pal_idx;
    logic           r_to_pal, n_to_pal;
    logic [31:0]    r_px, n_px;
    logic [31:0]    r_y, n_y;
    logic [31:0]    r_limit, n_limit;
    logic [PAW-1:0] r_row_base, n_row_base;
    logic [PAW-1:0] r_paddr, n_paddr;
    logic [1:0]     r_cls, n_cls;
    logic           r_in_dec, n_in_dec;
    logic [PAW-1:0] r_clr, n_clr;
    logic           r_clr_ret, n_clr_ret;   // sweep ends in a result
    logic [7:0]     r_bb, n_bb, r_rb, n_rb;
    logic           r_out_valid, n_out_valid;
    logic [1:0]     r_out_status, n_out_status;
    logic [30:0]    r_out_rows, n_out_rows;
    logic [7:0]     r_out_bb, n_out_bb, r_out_rb, n_out_rb;

    // memory ports
    logic           plane_rd, plane_wr;
    logic [PAW-1:0] plane_rd_addr, plane_wr_addr;
    logic [15:0]    plane_wdata, plane_rdata;
    logic           row_wr, row_rd;
    logic [RAW-1:0] row_rd_addr;
    logic [7:0]     row_rdata;
    logic           pal_clr, pal_wr, pal_rd;
    logic [PIW-1:0] pal_rd_addr;
    logic [1:0]     pal_rdata;
    logic [1:0]     cls;
    bst_pkg::t_rgb  pix;

    // scratch
    logic [31:0]    cur_y, rbc_inc, w_fin, h_fin, pos, addr32;
    logic [32:0]    half_w;
    logic [7:0]     v, mask;
    logic [PAW-1:0] paint_addr;

    assign pix = '{r: r_b2, g: r_b1, b: r_b0};

    always_comb begin
        n_state = r_state;   n_op = r_op;           n_din = r_din;
        n_raddr = r_raddr;   n_hcount = r_hcount;   n_sig = r_sig;
        n_off_sh = r_off_sh; n_w_sh = r_w_sh;       n_h_sh = r_h_sh;
        n_bpp_sh = r_bpp_sh; n_compr_sh = r_compr_sh;
        n_pix_off = r_pix_off; n_fpos = r_fpos;     n_width = r_width;
        n_height = r_height; n_top = r_top;         n_mode = r_mode;
        n_pal_recv = r_pal_recv; n_pal_len = r_pal_len; n_stride = r_stride;
        n_pix_bytes = r_pix_bytes; n_row_index = r_row_index; n_rbc = r_rbc;
        n_phase = r_phase;   n_pixcnt = r_pixcnt;   n_ok = r_ok;
        n_err = r_err;       n_b0 = r_b0;           n_b1 = r_b1;
        n_b2 = r_b2;         n_pal_idx = r_pal_idx; n_to_pal = r_to_pal;
        n_px = r_px;         n_y = r_y;             n_limit = r_limit;
        n_row_base = r_row_base; n_paddr = r_paddr; n_cls = r_cls;
        n_in_dec = r_in_dec; n_clr = r_clr;         n_clr_ret = r_clr_ret;
        n_bb = r_bb;         n_rb = r_rb;
        n_out_valid = r_out_valid; n_out_status = r_out_status;
        n_out_rows = r_out_rows; n_out_bb = r_out_bb; n_out_rb = r_out_rb;

        plane_rd = 1'b0; plane_wr = 1'b0;
        plane_rd_addr = '0; plane_wr_addr = '0; plane_wdata = '0;
        row_wr = 1'b0; row_rd = 1'b0; row_rd_addr = '0;
        pal_clr = 1'b0; pal_wr = 1'b0; pal_rd = 1'b0; pal_rd_addr = '0;

        cur_y   = r_top ? r_row_index : (r_height - 32'd1 - r_row_index);
        rbc_inc = r_rbc + 32'd1;
        w_fin   = r_w_sh[31] ? 32'd0 : r_w_sh;
        h_fin   = r_h_sh[31] ? (32'd0 - r_h_sh) : r_h_sh;
        half_w  = ({1'b0, w_fin} + 33'd1) >> 1;
        pos     = (r_mode == bst_pkg::MODE_8) ? r_px : (r_px >> 1);
        addr32  = {19'd0, r_raddr};
        v       = row_rdata;
        if (r_mode == bst_pkg::MODE_4) begin
            v = r_px[0] ? {4'd0, row_rdata[3:0]} : {4'd0, row_rdata[7:4]};
        end
        mask       = 8'h80 >> r_px[2:0];
        paint_addr = r_row_base + PAW'(r_px >> 3);

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.operation;
                    n_din   = i_in.data_byte;
                    n_raddr = i_in.read_address;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_bb    = 8'd0;
                n_rb    = 8'd0;
                n_state = S_DONE;
                if (r_op == bst_pkg::OP_START) begin
                    pal_clr = 1'b1;
                    n_hcount = '0;   n_pix_off = '0;  n_fpos = '0;
                    n_width = '0;    n_height = '0;   n_top = 1'b0;
                    n_mode = bst_pkg::MODE_24;        n_pal_recv = '0;
                    n_pal_len = '0;  n_stride = '0;   n_pix_bytes = '0;
                    n_row_index = '0; n_rbc = '0;     n_phase = '0;
                    n_pixcnt = '0;   n_ok = 1'b1;     n_err = bst_pkg::ST_OK;
                end else if (r_op == bst_pkg::OP_READ) begin
                    if (addr32 < 32'(PB)) begin
                        plane_rd      = 1'b1;
                        plane_rd_addr = addr32[PAW-1:0];
                        n_state       = S_READ;
                    end
                end else if (r_op == bst_pkg::OP_BYTE && r_ok) begin
                    if (r_hcount < 6'(bst_pkg::HEADER_BYTES)) begin
                        // header: keep only the fields that matter
                        if (r_hcount <= 6'd1)  n_sig = {r_din, r_sig[15:8]};
                        if (r_hcount >= 6'd10 && r_hcount <= 6'd13)
                            n_off_sh = {r_din, r_off_sh[31:8]};
                        if (r_hcount >= 6'd18 && r_hcount <= 6'd21)
                            n_w_sh = {r_din, r_w_sh[31:8]};
                        if (r_hcount >= 6'd22 && r_hcount <= 6'd25)
                            n_h_sh = {r_din, r_h_sh[31:8]};
                        if (r_hcount >= 6'd28 && r_hcount <= 6'd29)
                            n_bpp_sh = {r_din, r_bpp_sh[15:8]};
                        if (r_hcount >= 6'd30 && r_hcount <= 6'd33)
                            n_compr_sh = {r_din, r_compr_sh[31:8]};
                        n_hcount = r_hcount + 6'd1;
                        n_fpos   = r_fpos + 32'd1;
                        if (r_hcount == 6'(bst_pkg::HEADER_BYTES - 1)) begin
                            n_state = S_HDR_FIN;
                        end
                    end else if (r_mode != bst_pkg::MODE_24 && r_pal_recv < r_pal_len) begin
                        // palette entry bytes: blue, green, red, pad
                        case (r_pal_recv[1:0])
                            2'd0:    n_b0 = r_din;
                            2'd1:    n_b1 = r_din;
                            2'd2:    n_b2 = r_din;
                            default: ;
                        endcase
                        n_pal_recv = r_pal_recv + 32'd1;
                        n_fpos     = r_fpos + 32'd1;
                        if (r_pal_recv[1:0] == 2'd3 &&
                            (r_pal_recv >> 2) < 32'(PALETTE_ENTRIES)) begin
                            n_pal_idx = PIW'(r_pal_recv >> 2);
                            n_to_pal  = 1'b1;
                            n_state   = S_CLS1;
                        end
                    end else if (r_fpos < r_pix_off) begin
                        n_fpos = r_fpos + 32'd1;
                    end else if (r_row_index < r_height) begin
                        if (r_fpos != 32'hFFFF_FFFF) n_fpos = r_fpos + 32'd1;
                        if (r_stride == 32'd0) begin
                            n_row_index = r_height;
                        end else if (r_mode == bst_pkg::MODE_24) begin
                            if (r_rbc < r_pix_bytes) begin
                                case (r_phase)
                                    2'd0:    n_b0 = r_din;
                                    2'd1:    n_b1 = r_din;
                                    default: n_b2 = r_din;
                                endcase
                                if (r_phase == 2'd2) begin
                                    n_phase  = 2'd0;
                                    n_px     = r_pixcnt;
                                    n_pixcnt = r_pixcnt + 32'd1;
                                    n_y      = cur_y;
                                    n_to_pal = 1'b0;
                                    n_state  = S_CLS1;
                                end else begin
                                    n_phase = r_phase + 2'd1;
                                end
                            end
                            if (rbc_inc == r_stride) begin
                                n_row_index = r_row_index + 32'd1;
                                n_rbc = '0;  n_phase = '0;  n_pixcnt = '0;
                            end else begin
                                n_rbc = rbc_inc;
                            end
                        end else begin
                            row_wr = r_rbc < 32'(ROW_BUFFER_BYTES);
                            if (rbc_inc == r_stride) begin
                                // row complete: decode it from the row RAM
                                n_y         = cur_y;
                                n_limit     = (r_width < 32'(PANEL_WIDTH)) ?
                                              r_width : 32'(PANEL_WIDTH);
                                n_px        = '0;
                                n_row_index = r_row_index + 32'd1;
                                n_rbc       = '0;
                                n_state     = S_DEC_BASE;
                            end else begin
                                n_rbc = rbc_inc;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                n_bb    = plane_rdata[15:8];
                n_rb    = plane_rdata[7:0];
                n_state = S_DONE;
            end
            S_HDR_FIN: begin
                n_pix_off = r_off_sh;
                if (r_sig != bst_pkg::BMP_MAGIC) begin
                    n_ok = 1'b0;  n_err = bst_pkg::ST_NOT_BMP;  n_state = S_DONE;
                end else if ((r_bpp_sh != 16'd4 && r_bpp_sh != 16'd8 && r_bpp_sh != 16'd24)
                             || r_compr_sh != 32'd0) begin
                    n_ok = 1'b0;  n_err = bst_pkg::ST_UNSUPPORTED;  n_state = S_DONE;
                end else begin
                    n_top       = r_h_sh[31];
                    n_height    = h_fin;
                    n_width     = w_fin;
                    n_pix_bytes = (w_fin << 1) + w_fin;
                    if (r_bpp_sh == 16'd24) begin
                        n_mode   = bst_pkg::MODE_24;
                        n_stride = ((w_fin << 1) + w_fin + 32'd3) & ~32'd3;
                    end else if (r_bpp_sh == 16'd8) begin
                        n_mode   = bst_pkg::MODE_8;
                        n_stride = (w_fin + 32'd3) & ~32'd3;
                    end else begin
                        n_mode   = bst_pkg::MODE_4;
                        n_stride = (half_w[31:0] + 32'd3) & ~32'd3;
                    end
                    n_pal_len = (r_bpp_sh != 16'd24 && r_off_sh >= 32'(bst_pkg::HEADER_BYTES))
                                ? r_off_sh - 32'(bst_pkg::HEADER_BYTES) : 32'd0;
                    n_clr     = '0;
                    n_clr_ret = 1'b1;
                    n_state   = S_CLEAR;
                end
            end
            S_CLEAR: begin
                plane_wr      = 1'b1;
                plane_wr_addr = r_clr;
                n_clr         = r_clr + PAW'(1);
                if (r_clr == PAW'(PB - 1)) begin
                    n_state = r_clr_ret ? S_DONE : S_IDLE;
                end
            end
            S_CLS1: begin
                n_row_base = PAW'(r_y[YW-1:0] * PRB);
                n_state    = S_CLS2;
            end
            S_CLS2: n_state = S_CLS3;
            S_CLS3: begin
                n_state = S_DONE;
                if (r_to_pal) begin
                    pal_wr = 1'b1;
                end else if (cls != bst_pkg::CLS_WHITE && r_px < 32'(PANEL_WIDTH)
                             && r_y < 32'(PANEL_HEIGHT)) begin
                    plane_rd      = 1'b1;
                    plane_rd_addr = paint_addr;
                    n_paddr       = paint_addr;
                    n_cls         = cls;
                    n_in_dec      = 1'b0;
                    n_state       = S_PAINT_WR;
                end
            end
            S_DEC_BASE: begin
                n_row_base = PAW'(r_y[YW-1:0] * PRB);
                n_state    = S_DEC_X;
            end
            S_DEC_X: begin
                if (r_px >= r_limit) begin
                    n_state = S_DONE;
                end else if (pos >= 32'(ROW_BUFFER_BYTES)) begin
                    n_px = r_px + 32'd1;      // beyond the row buffer: stays white
                end else begin
                    row_rd      = 1'b1;
                    row_rd_addr = pos[RAW-1:0];
                    n_state     = S_DEC_ROW;
                end
            end
            S_DEC_ROW: begin
                if ({1'b0, v} < 9'(PALETTE_ENTRIES)) begin
                    pal_rd      = 1'b1;
                    pal_rd_addr = v[PIW-1:0];
                    n_state     = S_DEC_PAL;
                end else begin
                    n_px    = r_px + 32'd1;
                    n_state = S_DEC_X;
                end
            end
            S_DEC_PAL: begin
                if (pal_rdata != bst_pkg::CLS_WHITE && r_y < 32'(PANEL_HEIGHT)) begin
                    plane_rd      = 1'b1;
                    plane_rd_addr = paint_addr;
                    n_paddr       = paint_addr;
                    n_cls         = pal_rdata;
                    n_in_dec      = 1'b1;
                    n_state       = S_PAINT_WR;
                end else begin
                    n_px    = r_px + 32'd1;
                    n_state = S_DEC_X;
                end
            end
            S_PAINT_WR: begin
                plane_wr      = 1'b1;
                plane_wr_addr = r_paddr;
                plane_wdata   = plane_rdata;
                if (r_cls == bst_pkg::CLS_RED) begin
                    plane_wdata[7:0] = plane_rdata[7:0] | mask;
                end else begin
                    plane_wdata[15:8] = plane_rdata[15:8] | mask;
                end
                if (r_in_dec) begin
                    n_px    = r_px + 32'd1;
                    n_state = S_DEC_X;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_ok ? bst_pkg::ST_OK : r_err;
                    n_out_rows   = r_row_index[31] ? 31'h7FFF_FFFF : r_row_index[30:0];
                    n_out_bb     = r_bb;
                    n_out_rb     = r_rb;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;  r_clr <= '0;  r_clr_ret <= 1'b0;
            r_hcount <= '0;  r_pix_off <= '0;  r_fpos <= '0;  r_width <= '0;
            r_height <= '0;  r_top <= 1'b0;  r_mode <= bst_pkg::MODE_24;
            r_pal_recv <= '0;  r_pal_len <= '0;  r_stride <= '0;  r_pix_bytes <= '0;
            r_row_index <= '0;  r_rbc <= '0;  r_phase <= '0;  r_pixcnt <= '0;
            r_ok <= 1'b1;  r_err <= bst_pkg::ST_OK;  r_out_valid <= 1'b0;
            r_to_pal <= 1'b0;  r_in_dec <= 1'b0;
        end else begin
            r_state <= n_state;  r_clr <= n_clr;  r_clr_ret <= n_clr_ret;
            r_hcount <= n_hcount;  r_pix_off <= n_pix_off;  r_fpos <= n_fpos;
            r_width <= n_width;  r_height <= n_height;  r_top <= n_top;
            r_mode <= n_mode;  r_pal_recv <= n_pal_recv;  r_pal_len <= n_pal_len;
            r_stride <= n_stride;  r_pix_bytes <= n_pix_bytes;
            r_row_index <= n_row_index;  r_rbc <= n_rbc;  r_phase <= n_phase;
            r_pixcnt <= n_pixcnt;  r_ok <= n_ok;  r_err <= n_err;
            r_out_valid <= n_out_valid;  r_to_pal <= n_to_pal;  r_in_dec <= n_in_dec;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_din <= n_din;  r_raddr <= n_raddr;
        r_sig <= n_sig;  r_off_sh <= n_off_sh;  r_w_sh <= n_w_sh;  r_h_sh <= n_h_sh;
        r_bpp_sh <= n_bpp_sh;  r_compr_sh <= n_compr_sh;
        r_b0 <= n_b0;  r_b1 <= n_b1;  r_b2 <= n_b2;  r_pal_idx <= n_pal_idx;
        r_px <= n_px;  r_y <= n_y;  r_limit <= n_limit;  r_row_base <= n_row_base;
        r_paddr <= n_paddr;  r_cls <= n_cls;  r_bb <= n_bb;  r_rb <= n_rb;
        r_out_status <= n_out_status;  r_out_rows <= n_out_rows;
        r_out_bb <= n_out_bb;  r_out_rb <= n_out_rb;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.rows_done  = r_out_rows;
    assign o_out.black_byte = r_out_bb;
    assign o_out.red_byte   = r_out_rb;

    bst_classify u_classify (
        .i_clk (i_clk),
        .i_cfg (cfg),
        .i_pix (pix),
        .o_cls (cls)
    );

    bst_row_ram #(.DEPTH(ROW_BUFFER_BYTES), .AW(RAW)) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (row_wr),
        .i_wr_addr (r_rbc[RAW-1:0]),
        .i_wr_data (r_din),
        .i_rd_en   (row_rd),
        .i_rd_addr (row_rd_addr),
        .o_rd_data (row_rdata)
    );

    bst_palette_ram #(.DEPTH(PALETTE_ENTRIES), .AW(PIW)) u_palette_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (pal_clr),
        .i_wr_en   (pal_wr),
        .i_wr_addr (r_pal_idx),
        .i_wr_data (cls),
        .i_rd_en   (pal_rd),
        .i_rd_addr (pal_rd_addr),
        .o_rd_data (pal_rdata)
    );

    bst_plane_ram #(.DEPTH(PB), .AW(PAW)) u_plane_ram (
        .i_clk     (i_clk),
        .i_wr_en   (plane_wr),
        .i_wr_addr (plane_wr_addr),
        .i_wr_data (plane_wdata),
        .i_rd_en   (plane_rd),
        .i_rd_addr (plane_rd_addr),
        .o_rd_data (plane_rdata)
    );

    // ---------------- checks ----------------
    a_plane_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        plane_wr |-> (r_state == S_PAINT_WR || r_state == S_CLEAR))
        else $error("plane RAM written outside paint or sweep");

    a_hcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcount <= 6'(bst_pkg::HEADER_BYTES))
        else $error("header count past header length");

    a_rows_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_index <= r_height)
        else $error("row index beyond image height");

    a_paint_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAINT_WR) |-> $past(plane_rd))
        else $error("plane write without preceding read");

endmodule

FILE: sv/bst_classify.sv
`timescale 1ns / 1ps
// bst_classify: two-stage white/black/red pixel classifier.
// Depends on bst_pkg.
module bst_classify (
    input  logic          i_clk,
    input  bst_pkg::t_cfg i_cfg,
    input  bst_pkg::t_rgb i_pix,
    output logic [1:0]    o_cls
);
    logic        r_red;
    logic [17:0] r_lum;
    logic [17:0] r_lim;
    logic [1:0]  r_cls;

    // stage 1: red test, weighted sum, threshold scale
    always_ff @(posedge i_clk) begin
        r_red <= (i_pix.r > i_cfg.red_min) && (i_pix.g < i_cfg.gb_max)
                 && (i_pix.b < i_cfg.gb_max);
        r_lum <= ({10'd0, i_pix.r} * bst_pkg::LUM_R) + ({10'd0, i_pix.g} * bst_pkg::LUM_G)
                 + ({10'd0, i_pix.b} * bst_pkg::LUM_B);
        r_lim <= {10'd0, i_cfg.dark} * bst_pkg::LUM_UNIT;
    end

    // stage 2: decide
    always_ff @(posedge i_clk) begin
        if (r_red) begin
            r_cls <= bst_pkg::CLS_RED;
        end else if (r_lum < r_lim) begin
            r_cls <= bst_pkg::CLS_BLACK;
        end else begin
            r_cls <= bst_pkg::CLS_WHITE;
        end
    end

    assign o_cls = r_cls;
endmodule

FILE: sv/bst_row_ram.sv
`timescale 1ns / 1ps
// bst_row_ram: byte RAM holding one indexed pixel row, registered read.
// No dependencies.
module bst_row_ram #(
    parameter int DEPTH = 296,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: sv/bst_palette_ram.sv
`timescale 1ns / 1ps
// bst_palette_ram: palette class RAM; entries not written since clear read white.
// Depends on bst_pkg.
module bst_palette_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [1:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [1:0]    o_rd_data
);
    logic [1:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [1:0]       r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : bst_pkg::CLS_WHITE;
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: sv/bst_plane_ram.sv
`timescale 1ns / 1ps
// bst_plane_ram: black and red plane bytes side by side, {black, red}, registered read.
// No dependencies.
module bst_plane_ram #(
    parameter int DEPTH = 4736,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [15:0]   o_rd_data
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
